@@ design/playfair_digram_encipher_top_macros.svh @@
// assertion helpers for the playfair digram encipherer
`ifndef PLAYFAIR_DIGRAM_ENCIPHER_TOP_MACROS_SVH
`define PLAYFAIR_DIGRAM_ENCIPHER_TOP_MACROS_SVH

// clocked check, switched off while reset is held
`define PFDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define PFDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pfde_pkg.sv @@
`default_nettype none

package pfde_pkg;

    localparam int unsigned LetterW    = 5;
    localparam int unsigned CellW      = 5;
    localparam int unsigned NumLetters = 26;
    localparam int unsigned NumCells   = 25;

    typedef logic [LetterW-1:0] t_letter;
    typedef logic [CellW-1:0]   t_cell;
    typedef logic [2:0]         t_coord;

    localparam t_letter LetterI    = 5'd8;
    localparam t_letter LetterJ    = 5'd9;
    localparam t_letter LetterX    = 5'd23;
    localparam t_letter LastLetter = 5'd25;
    localparam t_cell   CellCount  = 5'd25;
    localparam t_coord  LastCoord  = 3'd4;

    typedef enum logic [1:0] {
        REQ_KEY     = 2'd0,
        REQ_KEY_END = 2'd1,
        REQ_TEXT    = 2'd2,
        REQ_MSG_END = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_PLACE,
        ST_RULE,
        ST_CELL,
        ST_LOAD
    } t_state;

    // write port and read addresses of both memories
    typedef struct packed {
        logic    wr_en;
        t_cell   wr_cell;
        t_letter wr_letter;
        t_letter rd_la;
        t_letter rd_lb;
        t_cell   rd_na;
        t_cell   rd_nb;
    } t_mem_req;

    // registered read data
    typedef struct packed {
        t_cell   pa;
        t_cell   pb;
        t_letter ca;
        t_letter cb;
    } t_mem_rsp;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_rc;

    // cell index (below 25) to row and column
    function automatic t_rc f_split(t_cell c);
        t_rc   rc;
        t_cell base;
        if (c >= 5'd20) begin
            rc.row = 3'd4;
        end else if (c >= 5'd15) begin
            rc.row = 3'd3;
        end else if (c >= 5'd10) begin
            rc.row = 3'd2;
        end else if (c >= 5'd5) begin
            rc.row = 3'd1;
        end else begin
            rc.row = 3'd0;
        end
        base   = {rc.row, 2'b00} + {2'b00, rc.row};
        rc.col = 3'(c - base);
        return rc;
    endfunction

    function automatic t_cell f_join(t_rc rc);
        return {rc.row, 2'b00} + {2'b00, rc.row} + {2'b00, rc.col};
    endfunction

    // step one place along a row or column, wrapping round
    function automatic t_coord f_next(t_coord v);
        return (v == LastCoord) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

`default_nettype wire

@@ design/playfair_digram_encipher_top.sv @@
// playfair digram encipherer, 5x5 square with J folded into I
// request channel (i_req_valid / o_req_ready) carries a type and a letter:
//   key letter, key end, plaintext letter, message end
// result channel (o_res_valid / i_res_ready) carries one cipher letter per
//   transfer, o_pair_last high on the second letter of each pair
// a key letter is written as it is taken; key end walks the whole alphabet
//   to fill the square, during which no request is taken
// a request that completes a pair passes the place lookup, rule, cell lookup
//   and load steps before it is in the result register; the two lookups are
//   the memory read stages, and the next request is taken after the load
// requests that produce nothing, key end apart, are taken at one per cycle
// the two cipher letters sit in an output register, so the next request is
//   taken while they wait; a further pair waits at the load step until the
//   receiver has drained the register
// synchronous reset clears the fill state, the held letter and the result
//   register; the square memories keep whatever they held and are rewritten
//   by the next key
`default_nettype none

module playfair_digram_encipher_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire logic [1:0]          i_req_type,
    input  wire pfde_pkg::t_letter   i_letter,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready,
    output pfde_pkg::t_letter        o_cipher_letter,
    output logic                     o_pair_last
);
    import pfde_pkg::*;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    t_cell    na;
    t_cell    nb;
    logic     outq_empty;
    logic     load;

    // sequencer: request decode, key fill walk, held letter
    pfde_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_letter     (i_letter),
        .o_mem_req    (mem_req),
        .i_na         (na),
        .i_nb         (nb),
        .i_outq_empty (outq_empty),
        .o_load       (load)
    );

    // square and letter-place memories, registered reads
    pfde_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    // row / column / rectangle rule on the two looked-up places
    pfde_rule u_rule (
        .i_pa (mem_rsp.pa),
        .i_pb (mem_rsp.pb),
        .o_na (na),
        .o_nb (nb)
    );

    // result register holding one enciphered pair
    pfde_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_c0            (mem_rsp.ca),
        .i_c1            (mem_rsp.cb),
        .i_res_ready     (i_res_ready),
        .o_res_valid     (o_res_valid),
        .o_cipher_letter (o_cipher_letter),
        .o_pair_last     (o_pair_last),
        .o_empty         (outq_empty)
    );

endmodule

`default_nettype wire

@@ design/pfde_mem.sv @@
`default_nettype none

module pfde_mem (
    input  wire logic              i_clk,
    input  wire pfde_pkg::t_mem_req i_req,
    output pfde_pkg::t_mem_rsp     o_rsp
);
    import pfde_pkg::*;

    t_letter r_square_mem [NumCells];
    t_cell   r_place_mem  [NumLetters];
    t_mem_rsp r_rsp;

    // square and letter place are written together, one letter per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_square_mem[i_req.wr_cell]  <= i_req.wr_letter;
            r_place_mem[i_req.wr_letter] <= i_req.wr_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp.pa <= r_place_mem[i_req.rd_la];
        r_rsp.pb <= r_place_mem[i_req.rd_lb];
        r_rsp.ca <= r_square_mem[i_req.rd_na];
        r_rsp.cb <= r_square_mem[i_req.rd_nb];
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

@@ design/pfde_rule.sv @@
`default_nettype none

module pfde_rule (
    input  wire pfde_pkg::t_cell i_pa,
    input  wire pfde_pkg::t_cell i_pb,
    output pfde_pkg::t_cell      o_na,
    output pfde_pkg::t_cell      o_nb
);
    import pfde_pkg::*;

    t_rc a_rc;
    t_rc b_rc;
    t_rc na_rc;
    t_rc nb_rc;

    always_comb begin
        a_rc  = f_split(i_pa);
        b_rc  = f_split(i_pb);
        na_rc = a_rc;
        nb_rc = b_rc;
        if (a_rc.row == b_rc.row) begin
            // same row: shift right
            na_rc.col = f_next(a_rc.col);
            nb_rc.col = f_next(b_rc.col);
        end else if (a_rc.col == b_rc.col) begin
            // same column: shift down
            na_rc.row = f_next(a_rc.row);
            nb_rc.row = f_next(b_rc.row);
        end else begin
            // rectangle: swap columns
            na_rc.col = b_rc.col;
            nb_rc.col = a_rc.col;
        end
    end

    assign o_na = f_join(na_rc);
    assign o_nb = f_join(nb_rc);

endmodule

`default_nettype wire

@@ design/pfde_outq.sv @@
`default_nettype none

module pfde_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire pfde_pkg::t_letter i_c0,
    input  wire pfde_pkg::t_letter i_c1,
    input  wire logic             i_res_ready,
    output logic                  o_res_valid,
    output pfde_pkg::t_letter     o_cipher_letter,
    output logic                  o_pair_last,
    output logic                  o_empty
);
    import pfde_pkg::*;

    logic    r_valid;
    logic    r_sel;
    t_letter r_c0;
    t_letter r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_load && !r_valid) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (r_valid && i_res_ready) begin
            r_sel   <= !r_sel;
            r_valid <= !r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !r_valid) begin
            r_c0 <= i_c0;
            r_c1 <= i_c1;
        end
    end

    assign o_res_valid     = r_valid;
    assign o_cipher_letter = r_sel ? r_c1 : r_c0;
    assign o_pair_last     = r_sel;
    assign o_empty         = !r_valid;

endmodule

`default_nettype wire

@@ design/pfde_ctrl.sv @@
`default_nettype none

module pfde_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire logic [1:0]       i_req_type,
    input  wire pfde_pkg::t_letter i_letter,
    output pfde_pkg::t_mem_req    o_mem_req,
    input  wire pfde_pkg::t_cell   i_na,
    input  wire pfde_pkg::t_cell   i_nb,
    input  wire logic             i_outq_empty,
    output logic                  o_load
);
    import pfde_pkg::*;

    t_state           r_state, n_state;
    logic [NumLetters-1:0] r_seen, n_seen;
    t_cell            r_fill, n_fill;
    logic             r_key_done, n_key_done;
    t_letter          r_held, n_held;
    logic             r_held_valid, n_held_valid;
    t_letter          r_walk, n_walk;
    t_letter          r_la, n_la;
    t_letter          r_lb, n_lb;
    t_cell            r_na, n_na;
    t_cell            r_nb, n_nb;

    logic    accept;
    logic    in_range;
    t_letter l_map;
    t_req    req;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign in_range    = (i_letter <= LastLetter);
    assign l_map       = (i_letter == LetterJ) ? LetterI : i_letter;
    assign req         = t_req'(i_req_type);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_KEY_END: begin
                            if (!r_key_done) n_state = ST_FILL;
                        end
                        REQ_TEXT: begin
                            if (r_key_done && in_range && r_held_valid) n_state = ST_PLACE;
                        end
                        REQ_MSG_END: begin
                            if (r_key_done && r_held_valid) n_state = ST_PLACE;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (r_walk == LastLetter) n_state = ST_IDLE;
            end
            ST_PLACE: n_state = ST_RULE;
            ST_RULE:  n_state = ST_CELL;
            ST_CELL:  n_state = ST_LOAD;
            ST_LOAD: begin
                if (i_outq_empty) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_seen       = r_seen;
        n_fill       = r_fill;
        n_key_done   = r_key_done;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_walk       = r_walk;
        n_la         = r_la;
        n_lb         = r_lb;
        n_na         = r_na;
        n_nb         = r_nb;
        o_load       = 1'b0;

        o_mem_req.wr_en     = 1'b0;
        o_mem_req.wr_cell   = r_fill;
        o_mem_req.wr_letter = l_map;
        o_mem_req.rd_la     = r_la;
        o_mem_req.rd_lb     = r_lb;
        o_mem_req.rd_na     = r_na;
        o_mem_req.rd_nb     = r_nb;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_KEY: begin
                            if (!r_key_done && in_range && !r_seen[l_map]
                                && (r_fill < CellCount)) begin
                                o_mem_req.wr_en = 1'b1;
                                n_seen[l_map]   = 1'b1;
                                n_fill          = r_fill + 5'd1;
                            end
                        end
                        REQ_KEY_END: begin
                            if (!r_key_done) n_walk = '0;
                        end
                        REQ_TEXT: begin
                            if (r_key_done && in_range) begin
                                if (!r_held_valid) begin
                                    n_held       = l_map;
                                    n_held_valid = 1'b1;
                                end else begin
                                    // doubled letter pairs with filler and stays held
                                    n_la         = r_held;
                                    n_lb         = (r_held == l_map) ? LetterX : l_map;
                                    n_held       = l_map;
                                    n_held_valid = (r_held == l_map);
                                end
                            end
                        end
                        REQ_MSG_END: begin
                            if (r_key_done && r_held_valid) begin
                                n_la         = r_held;
                                n_lb         = LetterX;
                                n_held_valid = 1'b0;
                            end
                        end
                        default: n_walk = r_walk;
                    endcase
                end
            end
            ST_FILL: begin
                o_mem_req.wr_letter = r_walk;
                if ((r_walk != LetterJ) && !r_seen[r_walk] && (r_fill < CellCount)) begin
                    o_mem_req.wr_en = 1'b1;
                    n_seen[r_walk]  = 1'b1;
                    n_fill          = r_fill + 5'd1;
                end
                n_walk = r_walk + 5'd1;
                if (r_walk == LastLetter) n_key_done = 1'b1;
            end
            ST_RULE: begin
                n_na = i_na;
                n_nb = i_nb;
            end
            ST_LOAD: begin
                o_load = i_outq_empty;
            end
            default: o_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seen       <= '0;
            r_fill       <= '0;
            r_key_done   <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_seen       <= n_seen;
            r_fill       <= n_fill;
            r_key_done   <= n_key_done;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        r_la   <= n_la;
        r_lb   <= n_lb;
        r_na   <= n_na;
        r_nb   <= n_nb;
    end

endmodule

`default_nettype wire

@@ design/pfde_checker.sv @@
`default_nettype none

`include "playfair_digram_encipher_top_macros.svh"

module pfde_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_req_ready,
    input wire logic       o_res_valid,
    input wire logic       i_res_ready,
    input wire logic [4:0] o_cipher_letter,
    input wire logic       o_pair_last
);

    // reset leaves the block ready with nothing to deliver
    `PFDE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> o_req_ready && !o_res_valid, "not idle after reset")

    // first letter of a pair is always followed by its partner
    `PFDE_ASSERT(a_pair_second, i_clk, i_rst_n, o_res_valid && i_res_ready && !o_pair_last |=> o_res_valid && o_pair_last, "pair partner missing")

    // a pair is never followed straight away by another result
    `PFDE_ASSERT(a_pair_gap, i_clk, i_rst_n, o_res_valid && i_res_ready && o_pair_last |=> !o_res_valid, "result after pair end")

    // cipher letters are real letters and never J
    `PFDE_ASSERT(a_letter_ok, i_clk, i_rst_n, o_res_valid |-> (o_cipher_letter <= 5'd25) && (o_cipher_letter != 5'd9), "bad cipher letter")

endmodule

bind playfair_digram_encipher_top pfde_checker u_pfde_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_req_ready     (o_req_ready),
    .o_res_valid     (o_res_valid),
    .i_res_ready     (i_res_ready),
    .o_cipher_letter (o_cipher_letter),
    .o_pair_last     (o_pair_last)
);

`default_nettype wire
